[sv/codon_switch_rate_matrix_entry_core_assert.svh]
// Assertion macros for the codon rate matrix entry core.
`ifndef CODON_SWITCH_RATE_MATRIX_ENTRY_CORE_ASSERT_SVH
`define CODON_SWITCH_RATE_MATRIX_ENTRY_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property while out of reset.
`define CSRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define CSRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSRE_ASSERT(lbl, prop, msg)
`define CSRE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[sv/csre_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants, the codon table and codon functions of the rate matrix entry core.
package csre_pkg;

  localparam int FREQ_BITS_DEF = 16;
  localparam int NUM_CODONS    = 61;
  localparam int MAT_DIM       = 122;
  localparam int NUM_LANES     = 9;
  localparam int ENTRY_W       = 28;
  localparam int GROUP_W       = 30;
  localparam int SUM_W         = 33;
  localparam int RATE_W        = 40;
  localparam logic [15:0] ONE_Q10 = 16'd1024;

  typedef enum logic [1:0] {
    REG_KAPPA        = 2'd0,
    REG_SWITCH_RATE  = 2'd1,
    REG_OMEGA_FIRST  = 2'd2,
    REG_OMEGA_SECOND = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_LOAD   = 3'd0,
    MODE_ZERO   = 3'd1,
    MODE_SWITCH = 3'd2,
    MODE_SAME   = 3'd3,
    MODE_DIAG   = 3'd4
  } mode_t;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  codon_index;
    logic [15:0] freq_value;
    logic [6:0]  row_index;
    logic [6:0]  col_index;
  } in_item_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate;
    logic                     was_load;
  } out_item_t;

  typedef struct packed {
    logic [15:0] kappa;
    logic [15:0] switch_rate;
    logic [15:0] omega_first;
    logic [15:0] omega_second;
  } cfg_t;

  typedef struct packed {
    logic       use_f;
    logic       kap;
    logic       nons;
    logic [5:0] addr;
  } lane_t;

  typedef struct packed {
    mode_t                     mode;
    logic                      cls;
    lane_t [NUM_LANES-1:0]     lanes;
  } dec_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

  localparam logic [4:0] AMINO_TBL [NUM_CODONS] = '{
    5'd8,  5'd11, 5'd8,  5'd11, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd14, 5'd15, 5'd14, 5'd15, 5'd7,  5'd7,  5'd10, 5'd7,
    5'd13, 5'd6,  5'd13, 5'd6,  5'd12, 5'd12, 5'd12, 5'd12,
    5'd14, 5'd14, 5'd14, 5'd14, 5'd9,  5'd9,  5'd9,  5'd9,
    5'd3,  5'd2,  5'd3,  5'd2,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd5,  5'd5,  5'd5,  5'd5,  5'd17, 5'd17, 5'd17, 5'd17,
    5'd19, 5'd19, 5'd15, 5'd15, 5'd15, 5'd15, 5'd1,  5'd18,
    5'd1,  5'd9,  5'd4,  5'd9,  5'd4
  };

  // Base triplet of a sense codon number, stop codons skipped.
  function automatic logic [5:0] triplet_of(input logic [5:0] n);
    logic [5:0] c;
    c = n;
    if (c >= 6'd48) c = c + 6'd1;
    if (c >= 6'd50) c = c + 6'd1;
    if (c >= 6'd56) c = c + 6'd1;
    return c;
  endfunction

  function automatic logic is_stop(input logic [5:0] t);
    return (t == 6'd48) || (t == 6'd50) || (t == 6'd56);
  endfunction

  // Sense codon number of a triplet; stop triplets map to some valid number.
  function automatic logic [5:0] sense_of(input logic [5:0] t);
    logic [5:0] s;
    if (t < 6'd48)       s = t;
    else if (t <= 6'd50) s = t - 6'd1;
    else if (t <= 6'd56) s = t - 6'd2;
    else                 s = t - 6'd3;
    return s;
  endfunction

endpackage

[sv/csre_decode.sv]
`timescale 1ns / 1ps
// Request decode: entry class, neighbor lanes and their factors.
module csre_decode
  import csre_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  in_item_t item,
  output dec_t     dec_r
);

  dec_t       dec_nxt;
  logic       ci, cj;
  logic [6:0] a7, b7;
  logic [5:0] a, b, ta, tb, nt, ns;

  always_comb begin
    ci = (item.row_index >= 7'(NUM_CODONS));
    cj = (item.col_index >= 7'(NUM_CODONS));
    a7 = ci ? item.row_index - 7'(NUM_CODONS) : item.row_index;
    b7 = cj ? item.col_index - 7'(NUM_CODONS) : item.col_index;
    a  = a7[5:0];
    b  = b7[5:0];
    ta = triplet_of(a);
    tb = triplet_of(b);
    dec_nxt.cls = ci;
    // pick the kind of entry
    if (!item.req_type) begin
      dec_nxt.mode = MODE_LOAD;
    end else if (item.row_index >= 7'(MAT_DIM) || item.col_index >= 7'(MAT_DIM)) begin
      dec_nxt.mode = MODE_ZERO;
    end else if (item.row_index == item.col_index) begin
      dec_nxt.mode = MODE_DIAG;
    end else if (ci != cj) begin
      dec_nxt.mode = (a == b) ? MODE_SWITCH : MODE_ZERO;
    end else begin
      dec_nxt.mode = MODE_SAME;
    end
    // one lane per single-base change of the row codon
    for (int p = 0; p < 3; p++) begin
      for (int d = 1; d < 4; d++) begin
        nt = ta ^ (6'(d) << (2 * p));
        ns = sense_of(nt);
        dec_nxt.lanes[3 * p + d - 1].addr = ns;
        dec_nxt.lanes[3 * p + d - 1].kap  = (d == 2);
        dec_nxt.lanes[3 * p + d - 1].nons = (AMINO_TBL[a] != AMINO_TBL[ns]);
        dec_nxt.lanes[3 * p + d - 1].use_f =
          (dec_nxt.mode == MODE_DIAG) ? !is_stop(nt) :
          ((dec_nxt.mode == MODE_SAME) && (nt == tb));
      end
    end
  end

  // advance the decoded item
  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

[sv/csre_lanes.sv]
`timescale 1ns / 1ps
// Frequency banks and the two-multiplier lane pipeline.
module csre_lanes
  import csre_pkg::*;
#(
  parameter int FREQ_BITS = FREQ_BITS_DEF
)
(
  input  logic                 clk,
  input  stage_en_t            en,
  input  cfg_t                 cfg,
  input  logic                 wr_en,
  input  logic [5:0]           wr_addr,
  input  logic [FREQ_BITS-1:0] wr_data,
  input  dec_t                 dec,
  output mode_t                mode_r,
  output logic [FREQ_BITS+31:0] prod_r [NUM_LANES]
);

  localparam int P1_W = FREQ_BITS + 16;
  localparam int P2_W = FREQ_BITS + 32;

  logic [FREQ_BITS-1:0] freq_r [NUM_LANES];
  logic [P1_W-1:0]      p1_r   [NUM_LANES];
  logic [NUM_LANES-1:0] kap_r, nons2_r, nons3_r;
  logic                 cls2_r, cls3_r;
  mode_t                mode2_r, mode3_r;
  logic [15:0]          omega;

  assign omega = cls3_r ? cfg.omega_second : cfg.omega_first;

  // one replicated bank per lane so all neighbors read at once
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    logic [FREQ_BITS-1:0] mem [NUM_CODONS];

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
    end

    always_ff @(posedge clk) begin
      if (en.s2) begin
        freq_r[k]  <= dec.lanes[k].use_f ? mem[dec.lanes[k].addr] : '0;
        kap_r[k]   <= dec.lanes[k].kap;
        nons2_r[k] <= dec.lanes[k].nons;
      end
      if (en.s3) begin
        p1_r[k]    <= P1_W'(freq_r[k]) *
                      P1_W'(kap_r[k] ? cfg.kappa : ONE_Q10);
        nons3_r[k] <= nons2_r[k];
      end
      if (en.s4) begin
        prod_r[k]  <= P2_W'(p1_r[k]) *
                      P2_W'(nons3_r[k] ? omega : ONE_Q10);
      end
    end
  end

  // carry the item's tag alongside the lanes
  always_ff @(posedge clk) begin
    if (en.s2) begin
      mode2_r <= dec.mode;
      cls2_r  <= dec.cls;
    end
    if (en.s3) begin
      mode3_r <= mode2_r;
      cls3_r  <= cls2_r;
    end
    if (en.s4) begin
      mode_r  <= mode3_r;
    end
  end

endmodule

[sv/csre_reduce.sv]
`timescale 1ns / 1ps
// Lane truncation, row sum and result formatting.
module csre_reduce
  import csre_pkg::*;
#(
  parameter int FREQ_BITS = FREQ_BITS_DEF
)
(
  input  logic                  clk,
  input  stage_en_t             en,
  input  cfg_t                  cfg,
  input  mode_t                 mode,
  input  logic [FREQ_BITS+31:0] prod [NUM_LANES],
  output out_item_t             out_r
);

  logic [GROUP_W-1:0] grp_r [3];
  mode_t              mode5_r;
  logic [SUM_W-1:0]   sw_q16, total;
  out_item_t          out_nxt;

  // drop the extra fraction bits and add lanes in groups of three
  always_ff @(posedge clk) begin
    if (en.s5) begin
      for (int g = 0; g < 3; g++) begin
        grp_r[g] <= GROUP_W'(prod[3 * g][FREQ_BITS+4 +: ENTRY_W]) +
                    GROUP_W'(prod[3 * g + 1][FREQ_BITS+4 +: ENTRY_W]) +
                    GROUP_W'(prod[3 * g + 2][FREQ_BITS+4 +: ENTRY_W]);
      end
      mode5_r <= mode;
    end
  end

  always_comb begin
    sw_q16 = SUM_W'({cfg.switch_rate, 6'b0});
    total  = SUM_W'(grp_r[0]) + SUM_W'(grp_r[1]) + SUM_W'(grp_r[2]);
    out_nxt.was_load = 1'b0;
    unique case (mode5_r)
      MODE_LOAD: begin
        out_nxt.rate     = '0;
        out_nxt.was_load = 1'b1;
      end
      MODE_SWITCH: out_nxt.rate = RATE_W'(sw_q16);
      MODE_SAME:   out_nxt.rate = RATE_W'(total);
      MODE_DIAG:   out_nxt.rate = -$signed(RATE_W'(total + sw_q16));
      default:     out_nxt.rate = '0;
    endcase
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (en.s6) begin
      out_r <= out_nxt;
    end
  end

endmodule

[sv/codon_switch_rate_matrix_entry_core.sv]
`timescale 1ns / 1ps
// Top level of the two-class codon rate matrix entry core.
// Takes one item per clock while no stage is stalled: a frequency load or a
// query for one entry of the 122x122 rate matrix, and presents one result item
// per item after it has passed six register stages, the last of which is the
// output register. The frequency store is kept in nine identical banks so all
// single-base neighbors of a row are read together; each lane then runs through
// two registered multipliers (kappa, then omega), and a two-level registered
// adder tree forms the row sum for diagonal entries. Loads write all banks as
// the item is accepted, so a query right behind a load already sees the new
// frequency. Stalls propagate stage by stage, so empty stages still take new
// items while a result waits.
module codon_switch_rate_matrix_entry_core
  import csre_pkg::*;
#(
  parameter int FREQ_BITS = FREQ_BITS_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

`include "codon_switch_rate_matrix_entry_core_assert.svh"

  localparam int NSTG = 6;

  cfg_t                  cfg_r, cfg_nxt;
  logic [NSTG-1:0]       vld_r, vld_nxt, adv;
  stage_en_t             en;
  logic                  wr_en;
  dec_t                  dec;
  mode_t                 lane_mode;
  logic [FREQ_BITS+31:0] prod [NUM_LANES];

  // write the configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KAPPA:        cfg_nxt.kappa        = cfg_wdata;
        REG_SWITCH_RATE:  cfg_nxt.switch_rate  = cfg_wdata;
        REG_OMEGA_FIRST:  cfg_nxt.omega_first  = cfg_wdata;
        REG_OMEGA_SECOND: cfg_nxt.omega_second = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{ONE_Q10, ONE_Q10, ONE_Q10, ONE_Q10};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // advance each stage when it is empty or its successor moves
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt = vld_r;
    if (adv[0]) vld_nxt[0] = in_valid;
    for (int i = 1; i < NSTG; i++) begin
      if (adv[i]) vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en        = '{adv[0], adv[1], adv[2], adv[3], adv[4], adv[5]};
  assign in_ready  = adv[0];
  assign out_valid = vld_r[NSTG-1];
  assign wr_en     = in_valid && in_ready && !in_data.req_type &&
                     (in_data.codon_index < 6'(NUM_CODONS));

  csre_decode u_decode (
    .clk   (clk),
    .en    (en.s1),
    .item  (in_data),
    .dec_r (dec)
  );

  csre_lanes #(.FREQ_BITS(FREQ_BITS)) u_lanes (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg_r),
    .wr_en   (wr_en),
    .wr_addr (in_data.codon_index),
    .wr_data (FREQ_BITS'(in_data.freq_value)),
    .dec     (dec),
    .mode_r  (lane_mode),
    .prod_r  (prod)
  );

  csre_reduce #(.FREQ_BITS(FREQ_BITS)) u_reduce (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg_r),
    .mode  (lane_mode),
    .prod  (prod),
    .out_r (out_data)
  );

  `CSRE_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "pipeline not empty after reset")
  `CSRE_ASSERT(a_load_zero, out_valid && out_data.was_load |-> out_data.rate == '0, "load ack with nonzero rate")
  `CSRE_ASSERT(a_full_when_blocked, !in_ready |-> &vld_r, "input blocked with a free stage")
  `CSRE_ASSERT(a_stall_keeps, out_valid && !out_ready |=> out_valid, "stalled result dropped")

endmodule

[test/codon_switch_rate_matrix_entry_core_test.sv]
`timescale 1ns / 1ps
// Self-checking test of the codon rate matrix entry core: frequency loads and entry queries.
module codon_switch_rate_matrix_entry_core_test;
  import csre_pkg::*;

  localparam int LIMIT_CYCLES = 200000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;

  codon_switch_rate_matrix_entry_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: frequencies and register copies.
  logic [15:0] freq_tbl [NUM_CODONS];
  logic [15:0] kap_r, sw_r, om1_r, om2_r;
  out_item_t   rate_queue [$];
  int          errors;
  int          cycles;
  int          out_wait;
  bit          stall_en;

  localparam logic [4:0] AMINO [NUM_CODONS] = '{
    5'd8,  5'd11, 5'd8,  5'd11, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd14, 5'd15, 5'd14, 5'd15, 5'd7,  5'd7,  5'd10, 5'd7,
    5'd13, 5'd6,  5'd13, 5'd6,  5'd12, 5'd12, 5'd12, 5'd12,
    5'd14, 5'd14, 5'd14, 5'd14, 5'd9,  5'd9,  5'd9,  5'd9,
    5'd3,  5'd2,  5'd3,  5'd2,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd5,  5'd5,  5'd5,  5'd5,  5'd17, 5'd17, 5'd17, 5'd17,
    5'd19, 5'd19, 5'd15, 5'd15, 5'd15, 5'd15, 5'd1,  5'd18,
    5'd1,  5'd9,  5'd4,  5'd9,  5'd4
  };

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [5:0] base_code(int n);
    int c;
    c = n;
    if (c >= 48) c++;
    if (c >= 50) c++;
    if (c >= 56) c++;
    return c[5:0];
  endfunction

  // Off-diagonal entry in Q16.16.
  function automatic logic [63:0] neighbor_rate(int i, int j);
    int ci, cj, a, b, nd, xb;
    logic [5:0] ta, tb;
    logic [63:0] k, w, prod;
    ci = (i >= NUM_CODONS); cj = (j >= NUM_CODONS);
    a = i - ci * NUM_CODONS; b = j - cj * NUM_CODONS;
    if (ci != cj) return (a == b) ? (64'(sw_r) << 6) : 64'd0;
    if (a == b) return 64'd0;
    ta = base_code(a); tb = base_code(b);
    nd = 0; xb = 0;
    for (int p = 0; p < 3; p++)
      if (ta[2*p +: 2] != tb[2*p +: 2]) begin
        nd++;
        xb = ta[2*p +: 2] ^ tb[2*p +: 2];
      end
    if (nd != 1) return 64'd0;
    k = (xb == 2) ? 64'(kap_r) : 64'd1024;
    w = 64'd1024;
    if (AMINO[a] != AMINO[b]) w = ci ? 64'(om2_r) : 64'(om1_r);
    prod = (64'(freq_tbl[b]) * k * w) >> 20;
    return (prod > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : prod;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    logic [63:0] sum;
    int row, col;
    r = '0;
    if (!it.req_type) begin
      if (it.codon_index < NUM_CODONS) begin
        freq_tbl[it.codon_index] = it.freq_value;
      end
      r.was_load = 1'b1;
      return r;
    end
    row = it.row_index; col = it.col_index;
    if (row < MAT_DIM && col < MAT_DIM) begin
      if (row != col) r.rate = 40'(neighbor_rate(row, col));
      else begin
        sum = 0;
        for (int j = 0; j < MAT_DIM; j++) if (j != row) sum += neighbor_rate(row, j);
        if (sum > (64'd1 << 39)) sum = 64'd1 << 39;
        r.rate = 40'(64'd0 - sum);
      end
    end
    return r;
  endfunction

  // Send one item, after a random gap when stalls are enabled; predict at acceptance.
  // Valid stays high after acceptance so items can follow back to back.
  task automatic send_item(in_item_t it);
    int gap;
    out_item_t exp_item;
    gap = stall_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    exp_item = predict_result(it);
    rate_queue = {rate_queue, exp_item};
  endtask

  task automatic send_load(int c, logic [15:0] f);
    in_item_t it;
    it = '0;
    it.row_index = 7'($urandom); it.col_index = 7'($urandom);
    it.req_type = 1'b0; it.codon_index = c[5:0]; it.freq_value = f;
    send_item(it);
  endtask

  task automatic send_query(int r, int c);
    in_item_t it;
    it = '0;
    it.codon_index = 6'($urandom); it.freq_value = 16'($urandom);
    it.req_type = 1'b1; it.row_index = r[6:0]; it.col_index = c[6:0];
    send_item(it);
  endtask

  // Drop valid and wait for every expected result.
  task automatic drain();
    in_valid <= 1'b0;
    while (rate_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_KAPPA:        kap_r = v;
      REG_SWITCH_RATE:  sw_r  = v;
      REG_OMEGA_FIRST:  om1_r = v;
      REG_OMEGA_SECOND: om2_r = v;
    endcase
  endtask

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rate_queue.size() == 0) begin
          $display("%0t: unexpected result rate=%h load=%b", $time,
                   out_data.rate, out_data.was_load);
          errors++;
        end else begin
          exp_r = rate_queue.pop_front();
          if (out_data.rate !== exp_r.rate) begin
            $display("%0t: rate expected %h actual %h", $time, exp_r.rate, out_data.rate);
            errors++;
          end
          if (out_data.was_load !== exp_r.was_load) begin
            $display("%0t: was_load expected %b actual %b", $time,
                     exp_r.was_load, out_data.was_load);
            errors++;
          end
        end
        out_wait = stall_en ? $urandom_range(0, 6) : 0;
      end
      // hold ready low until the drawn wait has run out
      if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Bound the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_loads();
    send_load(0, 16'hFFFF);
    send_load(63, 16'h1234);
    send_load(61, 16'h0000);
    for (int c = 0; c < NUM_CODONS; c++) send_load(c, 16'($urandom));
    send_load(60, 16'h0000);
    send_load(1, 16'hFFFF);
  endtask

  task automatic test_directed_queries();
    send_query(0, 0);
    send_query(121, 121);
    send_query(0, 61);
    send_query(61, 0);
    send_query(0, 1);
    send_query(1, 0);
    send_query(0, 2);
    send_query(70, 65);
    send_query(5, 127);
    send_query(127, 5);
    send_query(122, 122);
    send_query(1, 1);
    send_query(62, 62);
  endtask

  task automatic test_config_extremes();
    drain();
    write_reg(REG_KAPPA, 16'hFFFF);
    write_reg(REG_SWITCH_RATE, 16'hFFFF);
    write_reg(REG_OMEGA_FIRST, 16'hFFFF);
    write_reg(REG_OMEGA_SECOND, 16'hFFFF);
    send_load(1, 16'hFFFF);
    send_query(1, 1); send_query(0, 1); send_query(62, 62); send_query(3, 64);
    drain();
    write_reg(REG_KAPPA, 16'h0000);
    write_reg(REG_SWITCH_RATE, 16'h0000);
    write_reg(REG_OMEGA_FIRST, 16'h0000);
    write_reg(REG_OMEGA_SECOND, 16'h0000);
    send_query(1, 1); send_query(0, 2); send_query(61, 61);
    drain();
  endtask

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 2) send_load($urandom_range(0, 63), 16'($urandom));
      else if (r < 4) begin
        r = $urandom_range(0, 121);
        send_query(r, r);
      end else if (r == 4) send_query($urandom_range(0, 127), $urandom_range(0, 127));
      else begin
        r = $urandom_range(0, 121);
        send_query(r, (r + (($urandom_range(0, 1)) ? 61 : $urandom_range(1, 20))) % MAT_DIM);
      end
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(REG_KAPPA, 16'($urandom));
      write_reg(REG_SWITCH_RATE, 16'($urandom));
      write_reg(REG_OMEGA_FIRST, 16'($urandom_range(0, 4096)));
      write_reg(REG_OMEGA_SECOND, 16'($urandom));
      stall_en = (ph != 1);
      random_phase(100);
    end
    stall_en = 1'b1;
  endtask

  initial begin
    errors = 0; cycles = 0; out_wait = 0; stall_en = 1'b1;
    kap_r = ONE_Q10; sw_r = ONE_Q10; om1_r = ONE_Q10; om2_r = ONE_Q10;
    for (int c = 0; c < NUM_CODONS; c++) begin
      freq_tbl[c] = '0;
    end
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_KAPPA; cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // All frequencies are loaded before any query so no unwritten entry is read.
    test_loads();
    test_directed_queries();
    test_config_extremes();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && rate_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
